>>> rtl/dkv_pkg.sv
// ----------------------------------------------------------------------------
// dkv_pkg
// Shared constants, request and status codes, and control structs for the
// dense packed key-value table.
// ----------------------------------------------------------------------------
package dkv_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int TYPE_W   = 3;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // request kinds
   localparam logic [TYPE_W-1:0] OP_INSERT = 3'd0;
   localparam logic [TYPE_W-1:0] OP_ERASE  = 3'd1;
   localparam logic [TYPE_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [TYPE_W-1:0] OP_READ   = 3'd3;
   localparam logic [TYPE_W-1:0] OP_WRITE  = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADPOS  = 3'd4;

   // write strobes toward the key and value memories
   typedef struct packed {
      logic key_we;
      logic val_we;
   } ram_ctl_type;

   // finished request toward the result register
   typedef struct packed {
      logic                done;
      logic [STATUS_W-1:0] status;
   } res_type;

endpackage

>>> rtl/dkv_ram.sv
// ----------------------------------------------------------------------------
// dkv_ram
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module dkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/dkv_ctrl.sv
// ----------------------------------------------------------------------------
// dkv_ctrl
// Request sequencer: scans the stored keys through one comparator, one slot
// per cycle, then appends, moves the last entry or fetches as required.
// ----------------------------------------------------------------------------
module dkv_ctrl #(
   parameter int CAPACITY = dkv_pkg::CAPACITY_DEF,
   localparam int AW      = $clog2(CAPACITY),
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dkv_pkg::TYPE_W-1:0]  req_type,
   input  logic [dkv_pkg::KEY_W-1:0]   req_key,
   input  logic [dkv_pkg::VAL_W-1:0]   req_value,
   input  logic [dkv_pkg::POS_W-1:0]   req_position,
   input  logic                        out_free,
   input  logic [dkv_pkg::KEY_W-1:0]   key_rdata,
   input  logic [dkv_pkg::VAL_W-1:0]   val_rdata,
   output dkv_pkg::ram_ctl_type        ram_ctl,
   output logic [AW-1:0]               ram_raddr,
   output logic [AW-1:0]               ram_waddr,
   output logic [dkv_pkg::KEY_W-1:0]   ram_wkey,
   output logic [dkv_pkg::VAL_W-1:0]   ram_wval,
   output dkv_pkg::res_type            res,
   output logic [dkv_pkg::KEY_W-1:0]   res_key,
   output logic [dkv_pkg::VAL_W-1:0]   res_value,
   output logic [CNT_W-1:0]            res_count
);

   localparam int PW = CNT_W + dkv_pkg::POS_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_MOVE  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [AW-1:0]              cmp_ff, cmp_in;
   logic                       pend_ff, pend_in;
   logic [dkv_pkg::TYPE_W-1:0] op_ff, op_in;
   logic [dkv_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [dkv_pkg::VAL_W-1:0]  val_ff, val_in;

   logic             accept;
   logic [PW-1:0]    pos_wide;
   logic             pos_ok;
   logic [AW-1:0]    pos_addr;
   logic             hit;
   logic             full;
   logic [CNT_W-1:0] last_idx;

   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign pos_wide  = PW'(req_position);
   assign pos_ok    = pos_wide < PW'(count_ff);
   assign pos_addr  = pos_wide[AW-1:0];
   assign hit       = pend_ff && (key_rdata == key_ff);
   assign full      = count_ff >= CNT_W'(CAPACITY);
   assign last_idx  = count_ff - CNT_W'(1);
   assign res_count = count_in;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmp_in     = cmp_ff;
      pend_in    = pend_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      ram_ctl    = '0;
      ram_raddr  = idx_ff[AW-1:0];
      ram_waddr  = '0;
      ram_wkey   = key_ff;
      ram_wval   = val_ff;
      res.done   = 1'b0;
      res.status = dkv_pkg::ST_OK;
      res_key    = '0;
      res_value  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_type;
               key_in  = req_key;
               val_in  = req_value;
               idx_in  = '0;
               pend_in = 1'b0;
               case (req_type)
                  dkv_pkg::OP_INSERT,
                  dkv_pkg::OP_ERASE,
                  dkv_pkg::OP_LOOKUP: begin
                     state_in = S_SCAN;
                  end
                  dkv_pkg::OP_READ: begin
                     if (pos_ok) begin
                        ram_raddr = pos_addr;
                        state_in  = S_FETCH;
                     end else begin
                        res.done   = 1'b1;
                        res.status = dkv_pkg::ST_BADPOS;
                     end
                  end
                  dkv_pkg::OP_WRITE: begin
                     res.done = 1'b1;
                     if (pos_ok) begin
                        ram_ctl.val_we = 1'b1;
                        ram_waddr      = pos_addr;
                        ram_wval       = req_value;
                     end else begin
                        res.status = dkv_pkg::ST_BADPOS;
                     end
                  end
                  default: begin
                     res.done = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               case (op_ff)
                  dkv_pkg::OP_ERASE: begin
                     // fetch the last entry to move into the freed slot
                     ram_raddr = last_idx[AW-1:0];
                     state_in  = S_MOVE;
                  end
                  dkv_pkg::OP_LOOKUP: begin
                     ram_raddr = cmp_ff;
                     state_in  = S_FETCH;
                  end
                  default: begin
                     res.done   = 1'b1;
                     res.status = dkv_pkg::ST_PRESENT;
                     state_in   = S_IDLE;
                  end
               endcase
            end else if (idx_ff == count_ff) begin
               // every stored key compared, none matched
               res.done = 1'b1;
               state_in = S_IDLE;
               if (op_ff == dkv_pkg::OP_INSERT) begin
                  if (full) begin
                     res.status = dkv_pkg::ST_FULL;
                  end else begin
                     ram_ctl.key_we = 1'b1;
                     ram_ctl.val_we = 1'b1;
                     ram_waddr      = count_ff[AW-1:0];
                     count_in       = count_ff + CNT_W'(1);
                  end
               end else begin
                  res.status = dkv_pkg::ST_ABSENT;
               end
            end else begin
               // issue next slot; its key is compared next cycle
               ram_raddr = idx_ff[AW-1:0];
               cmp_in    = idx_ff[AW-1:0];
               idx_in    = idx_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end
         end
         S_FETCH: begin
            res.done  = 1'b1;
            res_value = val_rdata;
            if (op_ff == dkv_pkg::OP_READ) begin
               res_key = key_rdata;
            end
            state_in = S_IDLE;
         end
         S_MOVE: begin
            ram_ctl.key_we = 1'b1;
            ram_ctl.val_we = 1'b1;
            ram_waddr      = cmp_ff;
            ram_wkey       = key_rdata;
            ram_wval       = val_rdata;
            count_in       = last_idx;
            res.done       = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ff <= cmp_in;
      op_ff  <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index ran past the stored entries");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !res.done |=> $stable(count_ff))
      else $error("entry count changed without a finished request");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      res.done |=> (count_ff == $past(count_ff))
                || (count_ff == $past(count_ff) + CNT_W'(1))
                || (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      res.done |-> out_free)
      else $error("result finished while result register is occupied");
`endif

endmodule

>>> rtl/dense_packed_key_value_table.sv
// ----------------------------------------------------------------------------
// dense_packed_key_value_table
// Key-value table with entries packed at slots 0 .. count-1; swap-and-pop
// erase, key lookup by sequential match, and indexed read/write.
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_ready  type, key, value, position
//   rsp_      out        rsp_valid / rsp_ready  status, key, value, count
//
// Insert, erase and lookup scan the key memory one slot per cycle through a
// single comparator. A read at a valid position ends in the fetch state;
// writes at position, bad positions and unused kinds end when accepted.
// Reset clears the count, not the slots; slots past the last entry go unused.
// A request is accepted when the sequencer is idle and the result register
// is empty or being taken in the same cycle.
// ----------------------------------------------------------------------------
module dense_packed_key_value_table #(
   parameter int CAPACITY = dkv_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dkv_pkg::TYPE_W-1:0]         req_type,
   input  logic [dkv_pkg::KEY_W-1:0]          req_key,
   input  logic signed [dkv_pkg::VAL_W-1:0]   req_value,
   input  logic [dkv_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dkv_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dkv_pkg::KEY_W-1:0]          rsp_out_key,
   output logic signed [dkv_pkg::VAL_W-1:0]   rsp_out_value,
   output logic [dkv_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   dkv_pkg::ram_ctl_type       ram_ctl;
   dkv_pkg::res_type           res;
   logic [AW-1:0]              ram_raddr;
   logic [AW-1:0]              ram_waddr;
   logic [dkv_pkg::KEY_W-1:0]  ram_wkey;
   logic [dkv_pkg::VAL_W-1:0]  ram_wval;
   logic [dkv_pkg::KEY_W-1:0]  key_rdata;
   logic [dkv_pkg::VAL_W-1:0]  val_rdata;
   logic [dkv_pkg::KEY_W-1:0]  res_key;
   logic [dkv_pkg::VAL_W-1:0]  res_value;
   logic [CNT_W-1:0]           res_count;
   logic                       out_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dkv_pkg::STATUS_W-1:0]  status_ff;
   logic [dkv_pkg::KEY_W-1:0]     out_key_ff;
   logic [dkv_pkg::VAL_W-1:0]     out_value_ff;
   logic [dkv_pkg::COUNT_W-1:0]   count_ff;

   dkv_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_key      (req_key),
      .req_value    ($unsigned(req_value)),
      .req_position (req_position),
      .out_free     (out_free),
      .key_rdata    (key_rdata),
      .val_rdata    (val_rdata),
      .ram_ctl      (ram_ctl),
      .ram_raddr    (ram_raddr),
      .ram_waddr    (ram_waddr),
      .ram_wkey     (ram_wkey),
      .ram_wval     (ram_wval),
      .res          (res),
      .res_key      (res_key),
      .res_value    (res_value),
      .res_count    (res_count)
   );

   dkv_ram #(
      .WIDTH (dkv_pkg::KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_ctl.key_we),
      .waddr (ram_waddr),
      .wdata (ram_wkey),
      .raddr (ram_raddr),
      .rdata (key_rdata)
   );

   dkv_ram #(
      .WIDTH (dkv_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_val_ram (
      .clock (clock),
      .we    (ram_ctl.val_we),
      .waddr (ram_waddr),
      .wdata (ram_wval),
      .raddr (ram_raddr),
      .rdata (val_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // load on finish, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.done) begin
         status_ff    <= res.status;
         out_key_ff   <= res_key;
         out_value_ff <= res_value;
         count_ff     <= dkv_pkg::COUNT_W'(res_count);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_value   = $signed(out_value_ff);
   assign rsp_entry_count = count_ff;

endmodule
